[sv/quaternion_to_euler_angles_assert.svh]
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: assertion macros
// Concurrent check helpers shared by the RTL that asserts.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// same-cycle implication, ignored while reset is low
`define Q2E_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset as well
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/q2e_pkg.sv]
// ----------------------------------------------------------------------------
// q2e_pkg
// Widths, constants and the arctangent table for the quaternion to Euler core.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_ITERS  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

    localparam int QW     = 16;   // quaternion component
    localparam int PW     = 32;   // 16x16 product
    localparam int SW     = 34;   // product sums, units of 2^-28
    localparam int CW     = 38;   // CORDIC x/y datapath
    localparam int ZW     = 33;   // angle accumulator, units of 2^-28 rad
    localparam int RW     = 19;   // rounded angle before saturation
    localparam int MAG_W  = 28;
    localparam int SQ_W   = 56;
    localparam int RAD_W  = 57;
    localparam int ROOT_W = 29;
    localparam int ISQ_STEPS = 29;
    localparam int CORDIC_LAT = CORDIC_ITERS + 2;

    localparam logic signed [SW-1:0] ONE_Q28 = SW'(268435456);
    localparam logic signed [ZW-1:0] PI_Q28  = ZW'(843314857);
    localparam logic signed [15:0]   PI_Q13  = 16'sd25736;
    localparam logic signed [14:0]   HALF_PI_Q13 = 15'sd12868;

    typedef struct packed {
        logic signed [SW-1:0] sr;
        logic signed [SW-1:0] cr;
        logic signed [SW-1:0] sp;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] cy;
        logic                 clip;
        logic                 neg;
    } t_side;

    typedef struct packed {
        logic clip;
        logic neg;
    } t_clip;

    // atan(2^-i) in units of 2^-28 rad
    function automatic logic signed [ZW-1:0] atan_q28(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = ZW'(210828714);
            1:  a = ZW'(124459457);
            2:  a = ZW'(65760959);
            3:  a = ZW'(33381290);
            4:  a = ZW'(16755422);
            5:  a = ZW'(8385879);
            6:  a = ZW'(4193963);
            7:  a = ZW'(2097109);
            8:  a = ZW'(1048571);
            9:  a = ZW'(524287);
            10: a = ZW'(262144);
            11: a = ZW'(131072);
            12: a = ZW'(65536);
            13: a = ZW'(32768);
            14: a = ZW'(16384);
            15: a = ZW'(8192);
            16: a = ZW'(4096);
            17: a = ZW'(2048);
            18: a = ZW'(1024);
            19: a = ZW'(512);
            20: a = ZW'(256);
            21: a = ZW'(128);
            22: a = ZW'(64);
            23: a = ZW'(32);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[sv/q2e_isqrt.sv]
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module q2e_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [q2e_pkg::RAD_W-1:0]   i_rad,
    output logic [q2e_pkg::ROOT_W-1:0]  o_root
);
    import q2e_pkg::*;

    localparam int IW = RAD_W + 1;

    logic [IW-1:0] r_v [ISQ_STEPS];
    logic [IW-1:0] r_r [ISQ_STEPS];

    genvar j;
    generate
        for (j = 0; j < ISQ_STEPS; j++) begin : g_step
            localparam int K = ISQ_STEPS - 1 - j;
            localparam logic [IW-1:0] BIT = IW'(1) << (2 * K);
            logic [IW-1:0] v_in, r_in, tmp, n_v, n_r;

            if (j == 0) begin : g_first
                assign v_in = {1'b0, i_rad};
                assign r_in = '0;
            end else begin : g_rest
                assign v_in = r_v[j-1];
                assign r_in = r_r[j-1];
            end

            always_comb begin
                tmp = r_in + BIT;
                if (v_in >= tmp) begin
                    n_v = v_in - tmp;
                    n_r = (r_in >> 1) + BIT;
                end else begin
                    n_v = v_in;
                    n_r = r_in >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[j] <= n_v;
                    r_r[j] <= n_r;
                end
            end
        end
    endgenerate

    assign o_root = r_r[ISQ_STEPS-1][ROOT_W-1:0];

endmodule

[sv/q2e_cordic.sv]
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC atan2 with half-plane fold and Q3.13 rounding.
// ----------------------------------------------------------------------------
module q2e_cordic (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [q2e_pkg::CW-1:0]   i_y,
    input  logic signed [q2e_pkg::CW-1:0]   i_x,
    output logic signed [q2e_pkg::RW-1:0]   o_angle
);
    import q2e_pkg::*;

    logic signed [CW-1:0] r_x [CORDIC_ITERS+1];
    logic signed [CW-1:0] r_y [CORDIC_ITERS+1];
    logic signed [ZW-1:0] r_z [CORDIC_ITERS+1];
    logic signed [RW-1:0] r_angle;
    logic signed [ZW:0]   n_round;

    // fold the left half-plane onto the right
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y < 0) ? -PI_Q28 : PI_Q28;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    genvar s;
    generate
        for (s = 0; s < CORDIC_ITERS; s++) begin : g_iter
            localparam logic signed [ZW-1:0] ATAN = atan_q28(s);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_y[s] > 0) begin
                        r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                        r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                        r_z[s+1] <= r_z[s] + ATAN;
                    end else if (r_y[s] < 0) begin
                        r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                        r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                        r_z[s+1] <= r_z[s] - ATAN;
                    end else begin
                        r_x[s+1] <= r_x[s];
                        r_y[s+1] <= r_y[s];
                        r_z[s+1] <= r_z[s];
                    end
                end
            end
        end
    endgenerate

    // round half up to Q3.13
    assign n_round = (ZW+1)'(r_z[CORDIC_ITERS]) + (ZW+1)'(16384);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= RW'(n_round >>> 15);
        end
    end

    assign o_angle = r_angle;

endmodule

[sv/quaternion_to_euler_angles.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion (Q2.14) to roll, yaw (Q3.13 rad) and pitch (Q2.13 rad) with gimbal flag.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  request  | i_valid/o_ready, i_quat_w/x/y/z           | in
//  result   | o_valid/i_ready, o_roll/pitch/yaw_angle,  | out
//           | o_pitch_clamped                           |
//
//  One quaternion per cycle while the output is not stalled; the stages are
//  products, sums, pitch magnitude, square and radicand, 29 square-root
//  stages, CORDIC_ITERS + 2 CORDIC stages and the output register.
//  Synchronous active-low reset clears the valid bits only.
//  A stall at the output holds every stage; o_ready is low only while the
//  output register is full and not being taken.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [15:0]          i_quat_w,
    input  logic signed [15:0]          i_quat_x,
    input  logic signed [15:0]          i_quat_y,
    input  logic signed [15:0]          i_quat_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [15:0]          o_roll_angle,
    output logic signed [14:0]          o_pitch_angle,
    output logic signed [15:0]          o_yaw_angle,
    output logic                        o_pitch_clamped
);
    import q2e_pkg::*;

    `include "quaternion_to_euler_angles_assert.svh"

    localparam int PRE_LAT = 5;
    localparam int LAT     = PRE_LAT + ISQ_STEPS + CORDIC_LAT + 1;

    logic en;
    logic r_vld [LAT];

    // stage 1: products
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    // stage 2..5
    t_side               r_s2, r_s3, r_s4, r_s5;
    t_side               n_s3;
    logic [MAG_W-1:0]    r_mag;
    logic [SQ_W-1:0]     r_sq;
    logic [RAD_W-1:0]    r_rad;
    t_side               r_dly [ISQ_STEPS];
    t_clip               r_cdly [CORDIC_LAT];
    logic [ROOT_W-1:0]   root;
    logic signed [RW-1:0] roll_r, pitch_r, yaw_r;
    logic signed [15:0]  r_roll, r_yaw;
    logic signed [14:0]  r_pitch;
    logic                r_clamped;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2.sr   <= (SW'(r_wx) + SW'(r_yz)) <<< 1;
            r_s2.cr   <= ONE_Q28 - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
            r_s2.sp   <= (SW'(r_wy) - SW'(r_zx)) <<< 1;
            r_s2.sy   <= (SW'(r_wz) + SW'(r_xy)) <<< 1;
            r_s2.cy   <= ONE_Q28 - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
            r_s2.clip <= 1'b0;
            r_s2.neg  <= 1'b0;
        end
    end

    // gimbal test and pitch magnitude
    always_comb begin
        n_s3      = r_s2;
        n_s3.clip = (r_s2.sp >= ONE_Q28) || (r_s2.sp <= -ONE_Q28);
        n_s3.neg  = r_s2.sp < 0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3  <= n_s3;
            r_mag <= n_s3.clip ? '0
                   : (n_s3.neg ? MAG_W'(-r_s2.sp) : MAG_W'(r_s2.sp));
            r_s4  <= r_s3;
            r_sq  <= r_mag * r_mag;
            r_s5  <= r_s4;
            r_rad <= (RAD_W'(1) << SQ_W) - RAD_W'(r_sq);
        end
    end

    q2e_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= r_s5;
            for (int k = 1; k < ISQ_STEPS; k++) r_dly[k] <= r_dly[k-1];
            r_cdly[0] <= '{clip: r_dly[ISQ_STEPS-1].clip, neg: r_dly[ISQ_STEPS-1].neg};
            for (int k = 1; k < CORDIC_LAT; k++) r_cdly[k] <= r_cdly[k-1];
        end
    end

    q2e_cordic u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (CW'(r_dly[ISQ_STEPS-1].sr)),
        .i_x     (CW'(r_dly[ISQ_STEPS-1].cr)),
        .o_angle (roll_r)
    );

    q2e_cordic u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (CW'(r_dly[ISQ_STEPS-1].sp)),
        .i_x     (CW'({1'b0, root})),
        .o_angle (pitch_r)
    );

    q2e_cordic u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (CW'(r_dly[ISQ_STEPS-1].sy)),
        .i_x     (CW'(r_dly[ISQ_STEPS-1].cy)),
        .o_angle (yaw_r)
    );

    // saturate and hold the result
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (roll_r > RW'(PI_Q13))       r_roll <= PI_Q13;
            else if (roll_r < -RW'(PI_Q13)) r_roll <= -PI_Q13;
            else                            r_roll <= 16'(roll_r);

            if (yaw_r > RW'(PI_Q13))        r_yaw <= PI_Q13;
            else if (yaw_r < -RW'(PI_Q13))  r_yaw <= -PI_Q13;
            else                            r_yaw <= 16'(yaw_r);

            if (r_cdly[CORDIC_LAT-1].clip)
                r_pitch <= r_cdly[CORDIC_LAT-1].neg ? -HALF_PI_Q13 : HALF_PI_Q13;
            else if (pitch_r > RW'(HALF_PI_Q13))  r_pitch <= HALF_PI_Q13;
            else if (pitch_r < -RW'(HALF_PI_Q13)) r_pitch <= -HALF_PI_Q13;
            else                                  r_pitch <= 15'(pitch_r);

            r_clamped <= r_cdly[CORDIC_LAT-1].clip;
        end
    end

    assign o_roll_angle    = r_roll;
    assign o_pitch_angle   = r_pitch;
    assign o_yaw_angle     = r_yaw;
    assign o_pitch_clamped = r_clamped;

    `Q2E_ASSERT_NOW(a_clamp_pitch, o_valid && o_pitch_clamped, (o_pitch_angle == HALF_PI_Q13) || (o_pitch_angle == -HALF_PI_Q13), "clamped pitch is not +-pi/2")
    `Q2E_ASSERT_NOW(a_roll_range, o_valid, (o_roll_angle <= PI_Q13) && (o_roll_angle >= -PI_Q13), "roll out of range")
    `Q2E_ASSERT_NOW(a_yaw_range, o_valid, (o_yaw_angle <= PI_Q13) && (o_yaw_angle >= -PI_Q13), "yaw out of range")
    `Q2E_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_valid, "output valid after reset")

endmodule

[tb/quaternion_to_euler_angles_checker.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_checker
// Watches the request and result channels, computes the expected roll, pitch,
// yaw and gimbal flag for every accepted quaternion and compares in order.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic               i_out_valid,
    input  logic               i_ready,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [14:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    input  logic               i_pitch_clamped,
    output int                 o_errors,
    output int                 o_pending
);
    import q2e_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_euler;

    t_euler angles_q[$];

    localparam longint ONE28  = 64'sd268435456;
    localparam longint PI28   = 64'sd843314857;
    localparam int     NSTAGE = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic longint vector_angle(longint yv, longint xv);
        longint acc;
        longint xs;
        longint ys;
        acc = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            acc = (yv < 0) ? -PI28 : PI28;
            xv  = -xv;
            yv  = -yv;
        end
        for (int i = 0; i < NSTAGE; i++) begin
            xs = shr(xv, i);
            ys = shr(yv, i);
            if (yv > 0) begin
                xv  += ys;
                yv  -= xs;
                acc += longint'(atan_q28(i));
            end else if (yv < 0) begin
                xv  -= ys;
                yv  += xs;
                acc -= longint'(atan_q28(i));
            end
        end
        return acc;
    endfunction

    function automatic longint round_q13(longint a, longint lim);
        longint r;
        r = shr(a + (64'sd1 << 14), 15);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_euler euler_of(longint w, longint x, longint y, longint z);
        t_euler e;
        longint sp;
        longint unsigned mag;
        e.roll = 16'(round_q13(vector_angle(2 * (w * x + y * z),
                 ONE28 - 2 * (x * x + y * y)), 25736));
        e.yaw  = 16'(round_q13(vector_angle(2 * (w * z + x * y),
                 ONE28 - 2 * (y * y + z * z)), 25736));
        sp = 2 * (w * y - z * x);
        e.clamped = 1'b1;
        if (sp >= ONE28) begin
            e.pitch = 15'sd12868;
        end else if (sp <= -ONE28) begin
            e.pitch = -15'sd12868;
        end else begin
            e.clamped = 1'b0;
            mag = longint'(sp < 0 ? -sp : sp);
            e.pitch = 15'(round_q13(vector_angle(sp,
                      int_sqrt((64'd1 << 56) - mag * mag)), 12868));
        end
        return e;
    endfunction

    always_ff @(posedge i_clk) begin
        t_euler exp_e;
        int     n_errors;
        n_errors = o_errors;
        if (!i_rst_n) begin
            n_errors = 0;
        end else begin
            if (i_valid && i_in_ready)
                angles_q.push_back(euler_of(i_quat_w, i_quat_x, i_quat_y, i_quat_z));
            if (i_out_valid && i_ready) begin
                if (angles_q.size() == 0) begin
                    n_errors = n_errors + 1;
                    if (n_errors <= 10) $display("unexpected result at %0t", $time);
                end else begin
                    exp_e = angles_q.pop_front();
                    if (exp_e.roll !== i_roll_angle || exp_e.pitch !== i_pitch_angle ||
                        exp_e.yaw !== i_yaw_angle || exp_e.clamped !== i_pitch_clamped) begin
                        n_errors = n_errors + 1;
                        if (n_errors <= 10)
                            $display({"mismatch: exp r=%0d p=%0d y=%0d c=%0d",
                                      " got r=%0d p=%0d y=%0d c=%0d"},
                                exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.clamped,
                                i_roll_angle, i_pitch_angle, i_yaw_angle, i_pitch_clamped);
                    end
                end
            end
        end
        o_errors  <= n_errors;
        o_pending <= angles_q.size();
    end
endmodule

[tb/quaternion_to_euler_angles_tb.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Drives directed and random quaternions with random gaps and output stalls;
// the checker predicts every angle set and reports mismatches.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic signed [15:0] qw = '0, qx = '0, qy = '0, qz = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic signed [15:0] roll, yaw;
    logic signed [14:0] pitch;
    logic               clamped;
    int                 errors, pending;

    always #6 clk = ~clk;

    quaternion_to_euler_angles u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .o_ready(req_ready),
        .i_quat_w(qw), .i_quat_x(qx), .i_quat_y(qy), .i_quat_z(qz),
        .o_valid(res_valid), .i_ready(res_ready), .o_roll_angle(roll),
        .o_pitch_angle(pitch), .o_yaw_angle(yaw), .o_pitch_clamped(clamped)
    );

    quaternion_to_euler_angles_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .i_in_ready(req_ready),
        .i_quat_w(qw), .i_quat_x(qx), .i_quat_y(qy), .i_quat_z(qz),
        .i_out_valid(res_valid), .i_ready(res_ready), .i_roll_angle(roll),
        .i_pitch_angle(pitch), .i_yaw_angle(yaw), .i_pitch_clamped(clamped),
        .o_errors(errors), .o_pending(pending)
    );

    // random stall per result, with stall-free stretches
    initial begin
        int gap;
        forever begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!(res_valid && res_ready));
        end
    end

    // hold valid after the accept; the next call or the caller drops it
    task automatic send_quat(input logic [15:0] w, x, y, z, input bit no_gap);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        qw <= w; qx <= x; qy <= y; qz <= z;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rnd_comp(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 32768) - 16384);
            1: return 16'($urandom());
            default: return 16'($urandom_range(0, 4096) - 2048);
        endcase
    endfunction

    // random unit quaternion, renormalized in real arithmetic
    task automatic send_unit();
        real a, b, c, d, n;
        a = real'($urandom_range(0, 2000)) - 1000.0;
        b = real'($urandom_range(0, 2000)) - 1000.0;
        c = real'($urandom_range(0, 2000)) - 1000.0;
        d = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
        send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                  16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)),
                  $urandom_range(0, 7) == 0);
    endtask

    initial begin
        int m;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // identity, axis rotations, gimbal limits, extremes, zero
        send_quat(16384, 0, 0, 0, 0);
        send_quat(0, 16384, 0, 0, 0);
        send_quat(0, 0, 16384, 0, 0);
        send_quat(0, 0, 0, 16384, 0);
        send_quat(11585, 0, 11585, 0, 0);
        send_quat(11585, 0, -11585, 0, 0);
        send_quat(11585, 11585, 11585, -11585, 0);
        send_quat(11586, 0, 11586, 0, 0);
        send_quat(0, 0, 0, 0, 0);
        send_quat(-16384, -16384, -16384, -16384, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1);
        send_quat(16'h8000, 16'h7fff, 0, 16'h8000, 1);
        send_quat(16'hffff, 16'h5555, 16'haaaa, 16'h0001, 1);
        send_quat(-16384, 0, 0, 0, 0);
        send_quat(0, 11585, 0, 11585, 0);
        // hold off until every result is back
        req_valid <= 1'b0;
        while (pending != 0 || req_valid) @(negedge clk);
        for (int i = 0; i < 800; i++) begin
            m = $urandom_range(0, 9);
            if (m < 7) send_unit();
            else send_quat(rnd_comp(m - 7), rnd_comp(m - 7), rnd_comp(m - 7),
                           rnd_comp(m - 7), 0);
        end
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/q2e_pkg.sv
sv/q2e_isqrt.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_angles.sv
tb/quaternion_to_euler_angles_checker.sv
tb/quaternion_to_euler_angles_tb.sv
